[sv/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;
  localparam int unsigned HeapBytes    = 1024;
  localparam int unsigned FreeSegments = 32;
  localparam int unsigned LiveAllocs   = 32;
  localparam int unsigned DataHeader   = 12;
  localparam int unsigned FreeHeader   = 24;

  localparam int unsigned SegIdxW  = $clog2(FreeSegments);
  localparam int unsigned SegCntW  = $clog2(FreeSegments + 1);
  localparam int unsigned LiveIdxW = $clog2(LiveAllocs);
  localparam int unsigned LiveCntW = $clog2(LiveAllocs + 1);
  localparam int unsigned AddrW    = $clog2(HeapBytes);
  localparam int unsigned LenW     = $clog2(HeapBytes + 1);
  localparam int unsigned NeedW    = 12;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusNoFit    = 2'd1,
    StatusBadFree  = 2'd2,
    StatusFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic        op;
    logic [10:0] req_size;
    logic [10:0] handle;
  } req_t;

  typedef struct packed {
    logic [10:0] address;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StScanLive,
    StScanSeg,
    StDecide,
    StShiftUp,
    StShiftDown,
    StRespond
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic clr_idx;
    logic inc_idx;
    logic dec_idx;
    logic apply;
    logic shift_up_step;
    logic shift_down_step;
    logic finish_ok;
    logic finish_err;
    logic [1:0] err_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic live_done;
    logic live_hit;
    logic seg_done;
    logic seg_hit;
    logic need_remove;
    logic need_insert;
    logic table_full;
    logic shift_done;
  } sts_t;
endpackage
`default_nettype wire

[sv/ffha_datapath.sv]
`default_nettype none
module ffha_datapath
  import ffha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire req_t req_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  output rsp_t      rsp_o
);
  logic [AddrW-1:0]  seg_start_q [FreeSegments];
  logic [LenW-1:0]   seg_len_q   [FreeSegments];
  logic [SegCntW-1:0] seg_count_q;
  logic [AddrW-1:0]  live_start_q [LiveAllocs];
  logic [LenW-1:0]   live_len_q   [LiveAllocs];
  logic [LiveAllocs-1:0] live_valid_q;

  req_t req_q;
  logic [SegCntW-1:0] sidx_q;
  logic [LiveCntW-1:0] lidx_q;
  logic [LiveIdxW-1:0] slot_q;
  logic live_hit_q, seg_hit_q;
  logic [AddrW-1:0] fstart_q;
  logic [LenW-1:0]  flen_q;
  logic [SegCntW-1:0] pos_q;
  rsp_t rsp_q;

  logic [NeedW-1:0] need;
  logic [SegIdxW-1:0] sidx;
  logic [LiveIdxW-1:0] lidx;
  logic sidx_in;
  logic [NeedW-1:0] cur_len, cur_start, handle_cmp;
  logic [SegIdxW-1:0] pos, posm1;
  logic join_prev, join_next;
  logic [NeedW-1:0] rem, prev_end, f_end;

  assign need  = NeedW'(req_q.req_size) + NeedW'(FreeHeader);
  assign sidx  = sidx_q[SegIdxW-1:0];
  assign lidx  = lidx_q[LiveIdxW-1:0];
  assign sidx_in = sidx_q < seg_count_q;
  assign cur_len   = NeedW'(seg_len_q[sidx]);
  assign cur_start = NeedW'(seg_start_q[sidx]);
  assign handle_cmp = NeedW'(live_start_q[lidx]) + NeedW'(DataHeader);
  assign pos   = pos_q[SegIdxW-1:0];
  assign posm1 = pos - 1'b1;
  assign prev_end = NeedW'(seg_start_q[posm1]) + NeedW'(seg_len_q[posm1]);
  assign f_end = NeedW'(fstart_q) + NeedW'(flen_q);
  assign join_prev = (pos_q != '0) && (prev_end == NeedW'(fstart_q));
  assign join_next = (pos_q < seg_count_q) && (f_end == NeedW'(seg_start_q[pos]));
  assign rem = NeedW'(seg_len_q[pos]) - need;

  always_comb begin
    sts_o = '0;
    sts_o.is_free   = req_q.op == OpFree;
    sts_o.live_done = lidx_q == LiveCntW'(LiveAllocs);
    sts_o.live_hit  = live_hit_q;
    sts_o.seg_done  = !sidx_in;
    sts_o.seg_hit   = seg_hit_q;
    sts_o.table_full = seg_count_q == SegCntW'(FreeSegments);
    if (req_q.op == OpFree) begin
      sts_o.need_remove = join_prev && join_next;
      sts_o.need_insert = !join_prev && !join_next;
    end else begin
      sts_o.need_remove = rem < NeedW'(FreeHeader);
      sts_o.need_insert = 1'b0;
    end
    sts_o.shift_done = cmd_i.shift_up_step ? (sidx_q <= pos_q) :
                       (SegCntW'(sidx_q + 1'b1) >= seg_count_q);
    if (cmd_i.shift_up_step) sts_o.shift_done = sidx_q <= pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q  <= SegCntW'(1);
      live_valid_q <= '0;
      sidx_q <= '0;
      lidx_q <= '0;
      live_hit_q <= 1'b0;
      seg_hit_q <= 1'b0;
      slot_q <= '0;
      fstart_q <= '0;
      flen_q <= '0;
      pos_q <= '0;
      for (int i = 0; i < FreeSegments; i++) begin
        seg_start_q[i] <= '0;
        seg_len_q[i]   <= (i == 0) ? LenW'(HeapBytes) : '0;
      end
    end else begin
      if (cmd_i.load_req) begin
        live_hit_q <= 1'b0;
        seg_hit_q  <= 1'b0;
      end
      if (cmd_i.clr_idx) begin
        sidx_q <= '0;
        lidx_q <= '0;
        pos_q  <= '0;
      end
      if (cmd_i.inc_idx) begin
        // Live scan runs for free requests and allocate slot search alike.
        if (!sts_o.live_done && !live_hit_q) begin
          if (req_q.op == OpFree) begin
            if (live_valid_q[lidx] && handle_cmp == NeedW'(req_q.handle)) begin
              live_hit_q <= 1'b1;
              slot_q <= lidx;
              fstart_q <= live_start_q[lidx];
              flen_q <= live_len_q[lidx];
            end
          end else if (!live_valid_q[lidx]) begin
            live_hit_q <= 1'b1;
            slot_q <= lidx;
          end
          lidx_q <= lidx_q + 1'b1;
        end
        // A free needs the block's start before it can look for its place.
        if (sidx_in && !seg_hit_q && (req_q.op == OpAlloc || live_hit_q)) begin
          if (req_q.op == OpFree ? (cur_start > NeedW'(fstart_q)) : (cur_len >= need)) begin
            seg_hit_q <= 1'b1;
            pos_q <= sidx_q;
          end else begin
            sidx_q <= sidx_q + 1'b1;
            pos_q <= sidx_q + 1'b1;
          end
        end
      end
      if (cmd_i.dec_idx) sidx_q <= seg_count_q;
      if (cmd_i.apply) begin
        if (req_q.op == OpAlloc) begin
          live_valid_q[slot_q] <= 1'b1;
          live_start_q[slot_q] <= seg_start_q[pos];
          if (rem < NeedW'(FreeHeader)) begin
            live_len_q[slot_q] <= seg_len_q[pos];
            sidx_q <= pos_q;
          end else begin
            live_len_q[slot_q] <= LenW'(need);
            seg_start_q[pos] <= AddrW'(NeedW'(seg_start_q[pos]) + need);
            seg_len_q[pos] <= LenW'(rem);
          end
        end else begin
          live_valid_q[slot_q] <= 1'b0;
          if (join_prev && join_next) begin
            seg_len_q[posm1] <= LenW'(NeedW'(seg_len_q[posm1]) + NeedW'(flen_q)
                                      + NeedW'(seg_len_q[pos]));
            sidx_q <= pos_q;
          end else if (join_prev) begin
            seg_len_q[posm1] <= LenW'(NeedW'(seg_len_q[posm1]) + NeedW'(flen_q));
          end else if (join_next) begin
            seg_start_q[pos] <= fstart_q;
            seg_len_q[pos] <= LenW'(NeedW'(seg_len_q[pos]) + NeedW'(flen_q));
          end else begin
            sidx_q <= seg_count_q;
          end
        end
      end
      if (cmd_i.shift_down_step) begin
        if (SegCntW'(sidx_q + 1'b1) < seg_count_q) begin
          seg_start_q[sidx] <= seg_start_q[SegIdxW'(sidx_q + 1'b1)];
          seg_len_q[sidx]   <= seg_len_q[SegIdxW'(sidx_q + 1'b1)];
          sidx_q <= sidx_q + 1'b1;
        end else begin
          seg_start_q[sidx] <= '0;
          seg_len_q[sidx]   <= '0;
          seg_count_q <= seg_count_q - 1'b1;
        end
      end
      if (cmd_i.shift_up_step) begin
        if (sidx_q > pos_q) begin
          seg_start_q[sidx] <= seg_start_q[SegIdxW'(sidx_q - 1'b1)];
          seg_len_q[sidx]   <= seg_len_q[SegIdxW'(sidx_q - 1'b1)];
          sidx_q <= sidx_q - 1'b1;
        end else begin
          seg_start_q[pos] <= fstart_q;
          seg_len_q[pos]   <= flen_q;
          seg_count_q <= seg_count_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.apply) begin
      rsp_q.status <= StatusOk;
      rsp_q.address <= (req_q.op == OpAlloc) ?
          11'(NeedW'(seg_start_q[pos]) + NeedW'(DataHeader)) : '0;
    end
    if (cmd_i.finish_err) begin
      rsp_q.status <= cmd_i.err_code;
      rsp_q.address <= '0;
    end
  end

  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

[sv/ffha_ctrl.sv]
`default_nettype none
module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (in_valid_i) state_d = StScanLive;
      StScanLive: begin
        // A free with an unknown handle never starts the free-table scan.
        if ((sts_i.live_done || sts_i.live_hit) &&
            (sts_i.seg_done || sts_i.seg_hit || (sts_i.is_free && !sts_i.live_hit)))
          state_d = StDecide;
      end
      StScanSeg:  state_d = StDecide;
      StDecide: begin
        if (!sts_i.is_free && !sts_i.seg_hit) state_d = StRespond;
        else if (!sts_i.live_hit) state_d = StRespond;
        else if (sts_i.is_free && sts_i.need_insert && sts_i.table_full)
          state_d = StRespond;
        else if (sts_i.need_remove) state_d = StShiftDown;
        else if (sts_i.need_insert) state_d = StShiftUp;
        else state_d = StRespond;
      end
      StShiftUp:   if (sts_i.shift_done) state_d = StRespond;
      StShiftDown: if (sts_i.shift_done) state_d = StRespond;
      StRespond:   if (out_ready_i) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load_req = in_valid_i;
        cmd_o.clr_idx = in_valid_i;
      end
      StScanLive: cmd_o.inc_idx = 1'b1;
      StDecide: begin
        if (!sts_i.is_free && !sts_i.seg_hit) begin
          cmd_o.finish_err = 1'b1;
          cmd_o.err_code = StatusNoFit;
        end else if (!sts_i.live_hit) begin
          cmd_o.finish_err = 1'b1;
          cmd_o.err_code = sts_i.is_free ? StatusBadFree : StatusFull;
        end else if (sts_i.is_free && sts_i.need_insert && sts_i.table_full) begin
          cmd_o.finish_err = 1'b1;
          cmd_o.err_code = StatusFull;
        end else begin
          cmd_o.apply = 1'b1;
        end
      end
      StShiftUp:   cmd_o.shift_up_step = 1'b1;
      StShiftDown: cmd_o.shift_down_step = 1'b1;
      StRespond:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_resp_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o) else $error("no return to idle");
  a_exclusive_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.shift_up_step && cmd_o.shift_down_step)) else $error("two shifts");
`endif
endmodule
`default_nettype wire

[sv/first_fit_heap_allocator_unit.sv]
`default_nettype none
// First-fit heap allocator over a 1024-byte heap. Each request transaction yields one
// response transaction. An allocate scans the live-allocation table (for a free slot)
// and the sorted free-segment table (for the first fit) side by side, one entry of each
// per cycle. A free first scans the live table for its handle and only then the free
// table for its place. A removal or an insertion then shifts the free table one entry
// per cycle. One request is in work at a time; the response is held until taken, and
// a stalled receiver adds its stall to the request's time.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_data_o
);
  cmd_t cmd;
  sts_t sts;

  // Controller sequences the scan, update and shift phases.
  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // Datapath holds both tables and the response register.
  ffha_datapath u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );
endmodule
`default_nettype wire
